>>> sv/smdhu_pkg.sv
package smdhu_pkg;

  typedef enum logic [3:0] {
    FN_MULT    = 4'd0,
    FN_MULTU   = 4'd1,
    FN_DIV     = 4'd2,
    FN_DIVU    = 4'd3,
    FN_PMULTW  = 4'd4,
    FN_PMULTUW = 4'd5,
    FN_PDIVW   = 4'd6,
    FN_PDIVUW  = 4'd7,
    FN_PDIVBW  = 4'd8,
    FN_PMULTH  = 4'd9
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_OUT  = 2'd3
  } state_e;

  // Lane count of the divide array (one per word of the operand).
  localparam int unsigned NumLanes = 4;

  // Control to the divide lanes.
  typedef struct packed {
    logic start;
    logic sgn;
  } div_ctl_t;

  // Status from one divide lane.
  typedef struct packed {
    logic        done;
    logic        wr;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_sts_t;

endpackage

>>> sv/simd_mult_div_hilo_unit.sv
// Multiply/divide unit with 128-bit LO and HI. One transaction at a time:
// multiplies (MULT, MULTU, PMULTW, PMULTUW, PMULTH) pass through ST_MUL, word
// multiplies through the registered multiply lanes; divides wait in ST_DIV for
// the 32 iterations of the four bit-serial divide lanes, which run in
// parallel on the words of rs. Undefined codes go straight to ST_OUT, leave
// LO and HI unchanged and clear the destination. A result is held until taken; LO and HI reset to zero.
module simd_mult_div_hilo_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  func_i,
  input  logic [63:0] rs_low_i,
  input  logic [63:0] rs_high_i,
  input  logic [63:0] rt_low_i,
  input  logic [63:0] rt_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] lo_low_o,
  output logic [63:0] lo_high_o,
  output logic [63:0] hi_low_o,
  output logic [63:0] hi_high_o,
  output logic [63:0] dest_low_o,
  output logic [63:0] dest_high_o,
  output logic        dest_write_o
);

  smdhu_pkg::state_e state_q, state_d;
  logic [3:0]   fn_q;
  logic [127:0] rs_q, rt_q;
  logic [63:0]  lo_q [2];
  logic [63:0]  hi_q [2];
  logic [127:0] dest_q;
  logic         dw_q;
  logic         busy_q;
  logic         accept, take, mul_en, div_done, fin;
  smdhu_pkg::div_ctl_t dctl;
  smdhu_pkg::div_sts_t dsts [smdhu_pkg::NumLanes];
  logic [31:0]  dvd [smdhu_pkg::NumLanes];
  logic [31:0]  dvs [smdhu_pkg::NumLanes];
  logic [63:0]  prod [2];
  logic [31:0]  ph [8];
  logic [smdhu_pkg::NumLanes-1:0] done_vec;

  assign accept = in_valid_i && !in_stall_o;
  assign take   = out_valid_o && !out_stall_i;
  assign in_stall_o  = (state_q != smdhu_pkg::ST_IDLE) || busy_q;
  assign out_valid_o = (state_q == smdhu_pkg::ST_OUT);

  // Capture the operands of an accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fn_q <= func_i;
      rs_q <= {rs_high_i, rs_low_i};
      rt_q <= {rt_high_i, rt_low_i};
    end
  end

  // Divide lanes: word i of rs over word 0/2 of rt, or halfword 0 for PDIVBW.
  assign dctl.start = (state_q == smdhu_pkg::ST_IDLE) && (state_d == smdhu_pkg::ST_DIV);
  assign dctl.sgn   = (fn_q == smdhu_pkg::FN_DIV) || (fn_q == smdhu_pkg::FN_PDIVW) ||
                      (fn_q == smdhu_pkg::FN_PDIVBW);
  for (genvar g = 0; g < smdhu_pkg::NumLanes; g++) begin : g_div
    assign dvd[g] = rs_q[32*g +: 32];
    assign dvs[g] = (fn_q == smdhu_pkg::FN_PDIVBW) ? {{16{rt_q[15]}}, rt_q[15:0]} :
                    rt_q[64*(g/2) +: 32];
    assign done_vec[g] = dsts[g].done;
    smdhu_div_lane u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (dctl),
      .dvd_i  (dvd[g]),
      .dvs_i  (dvs[g]),
      .sts_o  (dsts[g])
    );
  end
  assign div_done = &done_vec;

  // Word multiply lanes on words 0 and 2.
  assign mul_en = (state_q == smdhu_pkg::ST_IDLE) && (state_d == smdhu_pkg::ST_MUL);
  for (genvar m = 0; m < 2; m++) begin : g_mul
    smdhu_mul_lane u_mul (
      .clk_i (clk_i),
      .en_i  (mul_en),
      .sgn_i ((fn_q == smdhu_pkg::FN_MULT) || (fn_q == smdhu_pkg::FN_PMULTW)),
      .a_i   (rs_q[64*m +: 32]),
      .b_i   (rt_q[64*m +: 32]),
      .p_o   (prod[m])
    );
  end

  // Halfword products for PMULTH (16x16, eight lanes).
  for (genvar h = 0; h < 8; h++) begin : g_hm
    assign ph[h] = $signed({{16{rs_q[16*h+15]}}, rs_q[16*h +: 16]}) *
                   $signed({{16{rt_q[16*h+15]}}, rt_q[16*h +: 16]});
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    fin = 1'b0;
    case (state_q)
      smdhu_pkg::ST_IDLE: begin
        if (busy_q) begin
          case (fn_q)
            smdhu_pkg::FN_MULT, smdhu_pkg::FN_MULTU, smdhu_pkg::FN_PMULTW,
            smdhu_pkg::FN_PMULTUW, smdhu_pkg::FN_PMULTH: state_d = smdhu_pkg::ST_MUL;
            smdhu_pkg::FN_DIV, smdhu_pkg::FN_DIVU, smdhu_pkg::FN_PDIVW,
            smdhu_pkg::FN_PDIVUW, smdhu_pkg::FN_PDIVBW: state_d = smdhu_pkg::ST_DIV;
            default: begin
              fin = 1'b1;
              state_d = smdhu_pkg::ST_OUT;
            end
          endcase
        end
      end
      smdhu_pkg::ST_MUL: begin
        fin = 1'b1;
        state_d = smdhu_pkg::ST_OUT;
      end
      smdhu_pkg::ST_DIV: begin
        if (div_done) begin
          fin = 1'b1;
          state_d = smdhu_pkg::ST_OUT;
        end
      end
      smdhu_pkg::ST_OUT: begin
        if (take) state_d = smdhu_pkg::ST_IDLE;
      end
      default: state_d = smdhu_pkg::ST_IDLE;
    endcase
  end

  // busy_q marks a captured transaction waiting to dispatch; it stalls the
  // input during that cycle so the accept edge and dispatch are separate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smdhu_pkg::ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) busy_q <= 1'b1;
      else if (state_q == smdhu_pkg::ST_IDLE && busy_q) busy_q <= 1'b0;
    end
  end

  // Merge lane results into LO, HI and the destination.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q[0] <= '0;
      lo_q[1] <= '0;
      hi_q[0] <= '0;
      hi_q[1] <= '0;
      dest_q  <= '0;
      dw_q    <= 1'b0;
    end else if (fin) begin
      dest_q <= '0;
      dw_q   <= 1'b0;
      case (fn_q)
        smdhu_pkg::FN_MULT, smdhu_pkg::FN_PMULTW: begin
          for (int n = 0; n < 2; n++) begin
            if (n == 0 || fn_q == smdhu_pkg::FN_PMULTW) begin
              lo_q[n] <= {{32{prod[n][31]}}, prod[n][31:0]};
              hi_q[n] <= {{32{prod[n][63]}}, prod[n][63:32]};
            end
          end
          if (fn_q == smdhu_pkg::FN_PMULTW) begin
            dest_q <= {prod[1], prod[0]};
            dw_q   <= 1'b1;
          end
        end
        smdhu_pkg::FN_MULTU, smdhu_pkg::FN_PMULTUW: begin
          for (int n = 0; n < 2; n++) begin
            if (n == 0 || fn_q == smdhu_pkg::FN_PMULTUW) begin
              lo_q[n] <= {32'd0, prod[n][31:0]};
              hi_q[n] <= {32'd0, prod[n][63:32]};
            end
          end
          if (fn_q == smdhu_pkg::FN_PMULTUW) begin
            dest_q <= {prod[1], prod[0]};
            dw_q   <= 1'b1;
          end
        end
        smdhu_pkg::FN_DIV, smdhu_pkg::FN_DIVU, smdhu_pkg::FN_PDIVW,
        smdhu_pkg::FN_PDIVUW: begin
          for (int n = 0; n < 2; n++) begin
            if ((n == 0 || fn_q == smdhu_pkg::FN_PDIVW || fn_q == smdhu_pkg::FN_PDIVUW)
                && dsts[2*n].wr) begin
              lo_q[n] <= {{32{dctl.sgn & dsts[2*n].quo[31]}}, dsts[2*n].quo};
              hi_q[n] <= {{32{dctl.sgn & dsts[2*n].rem[31]}}, dsts[2*n].rem};
            end
          end
        end
        smdhu_pkg::FN_PDIVBW: begin
          for (int i = 0; i < 4; i++) begin
            if (dsts[i].wr) begin
              lo_q[i/2][32*(i%2) +: 32] <= dsts[i].quo;
              hi_q[i/2][32*(i%2) +: 32] <= dsts[i].rem;
            end
          end
        end
        smdhu_pkg::FN_PMULTH: begin
          lo_q[0] <= {ph[1], ph[0]};
          lo_q[1] <= {ph[5], ph[4]};
          hi_q[0] <= {ph[3], ph[2]};
          hi_q[1] <= {ph[7], ph[6]};
          dest_q  <= {ph[6], ph[4], ph[2], ph[0]};
          dw_q    <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign lo_low_o     = lo_q[0];
  assign lo_high_o    = lo_q[1];
  assign hi_low_o     = hi_q[0];
  assign hi_high_o    = hi_q[1];
  assign dest_low_o   = dest_q[63:0];
  assign dest_high_o  = dest_q[127:64];
  assign dest_write_o = dw_q;

  // No new transaction while one is in flight.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !accept) else $error("accept while busy");
  // The low word of LO and the destination-write flag are stable while a result waits to be taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(lo_q[0]) && $stable(dw_q))
    else $error("result changed under stall");
  // Without a destination write the destination value is zero.
  a_dw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dw_q |-> (dest_q == '0))
    else $error("dest flag");
  // Divide only finishes after all lanes are done.
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smdhu_pkg::ST_DIV && fin) |-> div_done) else $error("early divide");

endmodule

>>> sv/smdhu_div_lane.sv
// One radix-2 restoring divide lane: 32 bits, one quotient bit per cycle.
module smdhu_div_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  smdhu_pkg::div_ctl_t  ctl_i,
  input  logic [31:0]          dvd_i,
  input  logic [31:0]          dvs_i,
  output smdhu_pkg::div_sts_t  sts_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic        nq_q, nq_d, nr_q, nr_d, wr_q, wr_d, ovf_q, ovf_d;
  logic [32:0] trial;
  logic [31:0] abs_a, abs_b;

  // Magnitudes of the operands.
  assign abs_a = (ctl_i.sgn && dvd_i[31]) ? (32'd0 - dvd_i) : dvd_i;
  assign abs_b = (ctl_i.sgn && dvs_i[31]) ? (32'd0 - dvs_i) : dvs_i;
  assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, dvs_q};

  // Start setup and shift-subtract iterations.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    nq_d   = nq_q;
    nr_d   = nr_q;
    wr_d   = wr_q;
    ovf_d  = ovf_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      quo_d  = abs_a;
      rem_d  = 33'd0;
      dvs_d  = abs_b;
      nq_d   = ctl_i.sgn && (dvd_i[31] ^ dvs_i[31]);
      nr_d   = ctl_i.sgn && dvd_i[31];
      wr_d   = (dvs_i != 32'd0);
      ovf_d  = ctl_i.sgn && (dvd_i == 32'h8000_0000) && (dvs_i == 32'hFFFF_FFFF);
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    nq_q  <= nq_d;
    nr_q  <= nr_d;
    wr_q  <= wr_d;
    ovf_q <= ovf_d;
  end

  // Sign fix-up of the finished result; signed overflow gives 0x80000000, remainder zero.
  always_comb begin
    sts_o.done = !busy_q;
    sts_o.wr   = wr_q;
    if (ovf_q) begin
      sts_o.quo = 32'h8000_0000;
      sts_o.rem = 32'd0;
    end else begin
      sts_o.quo = nq_q ? (32'd0 - quo_q) : quo_q;
      sts_o.rem = nr_q ? (32'd0 - rem_q[31:0]) : rem_q[31:0];
    end
  end

endmodule

>>> sv/smdhu_mul_lane.sv
// One 33x33 signed multiply lane with a registered product.
module smdhu_mul_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic        sgn_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic signed [32:0] a_ext, b_ext;
  logic signed [65:0] prod;
  logic [63:0]        p_q;

  assign a_ext = $signed({sgn_i & a_i[31], a_i});
  assign b_ext = $signed({sgn_i & b_i[31], b_i});
  assign prod  = a_ext * b_ext;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= prod[63:0];
    end
  end

  assign p_o = p_q;

endmodule
